/* rtl/tld_pkg.sv */
package tld_pkg;

  // Widths fixed by the item format.
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int REG_IDX_W  = 3;
  localparam int LINE_MAX_DEF = 32;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_BACKSPACE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CR        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NL        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_CR = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CR_IS_NL  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ADD_CR    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ECHO_MODE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MASK      = 3'd7;

  // Echo modes.
  localparam logic [1:0] ECHO_RAW  = 2'd1;
  localparam logic [1:0] ECHO_MASK = 2'd2;

  // Result destinations.
  localparam logic [1:0] DEST_TERM = 2'd0;
  localparam logic [1:0] DEST_LINE = 2'd1;
  localparam logic [1:0] DEST_EOL  = 2'd2;

  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [BYTE_W-1:0] PRINT_LO     = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI     = 8'h7E;

  typedef struct packed {
    logic [BYTE_W-1:0] backspace_char;
    logic [BYTE_W-1:0] cr_char;
    logic [BYTE_W-1:0] nl_char;
    logic              ignore_cr;
    logic              cr_is_newline;
    logic              add_cr_on_output;
    logic [1:0]        echo_mode;
    logic [BYTE_W-1:0] mask_char;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ECHO_CR,
    ST_ECHO,
    ST_EDIT,
    ST_REL_START,
    ST_REL_BYTE,
    ST_REL_END
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_BS,
    OP_NL,
    OP_STORE
  } op_t;

endpackage

/* rtl/terminal_line_discipline.sv */
// Terminal line discipline, canonical mode.
//
// The input channel (in_valid/in_ready) carries one byte per transfer: with
// command low it is a byte received from the terminal, with command high a
// byte from the host to be sent to the terminal. Each input transfer causes
// zero or more result transfers on the output channel (out_valid/out_ready):
// echo or host bytes for the terminal, stored line bytes for the host, and an
// end-of-line marker carrying the length. The last result of an item has
// last set. Registers are written through cfg_write/cfg_index/cfg_data,
// by the user only while the block is idle; the block does not enforce it.
//
// One item is handled at a time. An item is accepted and decoded; unless it
// is a dropped CR, any terminal bytes are then sent, the line is edited and
// any line release walks the stored bytes and ends with the end-of-line marker.
// The release rate of one byte a cycle while the receiver does not stall is
// set by the single read port of the line store.
//
// Reset restores the register defaults and empties the line; the contents of
// the line store are not cleared. When the receiver stalls the result stays
// in the output register and the sequencer waits; a new item may be taken as
// soon as the last result of the previous one sits in that register.
module terminal_line_discipline
  import tld_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [BYTE_W-1:0]    data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           destination,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [LEN_W-1:0]     line_length,
  output logic                 line_full,
  output logic                 last
);

  // The store address needs at least one bit, even for a single-byte line.
  localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  cfg_t              cfg;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  // Register file. Writes to single-bit and two-bit registers keep only the
  // low bits of the data word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.backspace_char   <= 8'd8;
      cfg.cr_char          <= 8'd13;
      cfg.nl_char          <= 8'd10;
      cfg.ignore_cr        <= 1'b0;
      cfg.cr_is_newline    <= 1'b1;
      cfg.add_cr_on_output <= 1'b1;
      cfg.echo_mode        <= 2'd0;
      cfg.mask_char        <= 8'd42;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BACKSPACE: cfg.backspace_char   <= cfg_data;
        REG_CR:        cfg.cr_char          <= cfg_data;
        REG_NL:        cfg.nl_char          <= cfg_data;
        REG_IGNORE_CR: cfg.ignore_cr        <= cfg_data[0];
        REG_CR_IS_NL:  cfg.cr_is_newline    <= cfg_data[0];
        REG_ADD_CR:    cfg.add_cr_on_output <= cfg_data[0];
        REG_ECHO_MODE: cfg.echo_mode        <= cfg_data[1:0];
        REG_MASK:      cfg.mask_char        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: decodes the item, emits terminal bytes and walks the line
  // store one byte a cycle on release while the receiver does not stall.
  tld_seq #(
    .LINE_MAX (LINE_MAX),
    .ADDR_W   (ADDR_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .destination (destination),
    .out_byte    (out_byte),
    .line_length (line_length),
    .line_full   (line_full),
    .last        (last),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // Line store with one write port and one registered read port.
  tld_line_mem #(
    .DEPTH  (LINE_MAX),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/tld_line_mem.sv */
module tld_line_mem
  import tld_pkg::*;
#(
  parameter int DEPTH  = LINE_MAX_DEF,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tld_seq.sv */
module tld_seq
  import tld_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  parameter int ADDR_W   = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        destination,
  output logic [BYTE_W-1:0] out_byte,
  output logic [LEN_W-1:0]  line_length,
  output logic              line_full,
  output logic              last,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [BYTE_W-1:0] mem_rdata
);

  localparam logic [LEN_W-1:0] LINE_LAST = LEN_W'(LINE_MAX - 1);
  localparam logic [LEN_W-1:0] LINE_TOP  = LEN_W'(LINE_MAX);

  state_t            state, state_next;
  logic              item_cmd;
  logic [BYTE_W-1:0] item_byte;
  logic [BYTE_W-1:0] term_byte;
  logic [BYTE_W-1:0] line_ch;
  op_t               op;
  logic              rel_pending;
  logic [LEN_W-1:0]  line_count;
  logic [LEN_W-1:0]  rel_idx;

  // Decode of the held item.
  logic              is_cr, drop, printable, dec_term_en, dec_rel;
  logic [BYTE_W-1:0] dec_ch, dec_term_byte;
  op_t               dec_op;

  logic              slot_free, idx_last, term_is_nl;
  logic              take_item, dec_load, out_load;
  logic              cnt_inc, cnt_dec, cnt_clr, idx_clr, idx_inc;
  logic [1:0]        destination_next;
  logic [BYTE_W-1:0] out_byte_next;
  logic [LEN_W-1:0]  line_length_next;
  logic              line_full_next, last_next;

  always_comb begin
    is_cr = (item_byte == cfg.cr_char);
    drop  = !item_cmd && is_cr && cfg.ignore_cr;
    if (!item_cmd && ((is_cr && cfg.cr_is_newline) || (!is_cr && item_byte == cfg.nl_char))) begin
      dec_ch = NEWLINE_CHAR;
    end else begin
      dec_ch = item_byte;
    end
    printable     = dec_ch inside {[PRINT_LO:PRINT_HI]};
    dec_term_en   = item_cmd || cfg.echo_mode == ECHO_RAW || cfg.echo_mode == ECHO_MASK;
    dec_term_byte = (!item_cmd && cfg.echo_mode == ECHO_MASK && printable) ?
                    cfg.mask_char : dec_ch;
    if (item_cmd) begin
      dec_op = OP_NONE;
    end else if (dec_ch == cfg.backspace_char) begin
      dec_op = OP_BS;
    end else if (dec_ch == NEWLINE_CHAR) begin
      dec_op = OP_NL;
    end else begin
      dec_op = OP_STORE;
    end
    dec_rel = (dec_op == OP_NL) || (dec_op == OP_STORE && line_count == LINE_LAST);
  end

  assign slot_free  = !out_valid || out_ready;
  assign idx_last   = (LEN_W'(rel_idx + LEN_W'(1)) == line_count);
  assign term_is_nl = (term_byte == NEWLINE_CHAR);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (drop) begin
          state_next = ST_IDLE;
        end else if (dec_term_en) begin
          state_next = (dec_term_byte == NEWLINE_CHAR && cfg.add_cr_on_output) ?
                       ST_ECHO_CR : ST_ECHO;
        end else begin
          state_next = ST_EDIT;
        end
      end
      ST_ECHO_CR: begin
        if (slot_free) state_next = ST_ECHO;
      end
      ST_ECHO: begin
        if (slot_free) state_next = ST_EDIT;
      end
      ST_EDIT: begin
        state_next = rel_pending ? ST_REL_START : ST_IDLE;
      end
      ST_REL_START: begin
        state_next = (line_count == '0) ? ST_REL_END : ST_REL_BYTE;
      end
      ST_REL_BYTE: begin
        if (slot_free && idx_last) state_next = ST_REL_END;
      end
      ST_REL_END: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    dec_load         = 1'b0;
    out_load         = 1'b0;
    cnt_inc          = 1'b0;
    cnt_dec          = 1'b0;
    cnt_clr          = 1'b0;
    idx_clr          = 1'b0;
    idx_inc          = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_raddr        = '0;
    destination_next = DEST_TERM;
    out_byte_next    = '0;
    line_length_next = '0;
    line_full_next   = 1'b0;
    last_next        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DECODE: begin
        dec_load = 1'b1;
      end
      ST_ECHO_CR: begin
        out_load      = slot_free;
        out_byte_next = cfg.cr_char;
      end
      ST_ECHO: begin
        out_load = slot_free;
        if (term_is_nl) begin
          out_byte_next = cfg.cr_is_newline ? cfg.cr_char : cfg.nl_char;
        end else begin
          out_byte_next = term_byte;
        end
        last_next = !rel_pending;
      end
      ST_EDIT: begin
        cnt_dec = (op == OP_BS) && (line_count != '0);
        cnt_inc = (op == OP_STORE);
        mem_we  = (op == OP_STORE);
      end
      ST_REL_START: begin
        idx_clr = 1'b1;
        mem_re  = 1'b1;
      end
      ST_REL_BYTE: begin
        out_load         = slot_free;
        idx_inc          = slot_free;
        mem_re           = slot_free && !idx_last;
        mem_raddr        = ADDR_W'(rel_idx + LEN_W'(1));
        destination_next = DEST_LINE;
        out_byte_next    = mem_rdata;
      end
      ST_REL_END: begin
        out_load         = slot_free;
        cnt_clr          = slot_free;
        destination_next = DEST_EOL;
        line_length_next = line_count;
        line_full_next   = (op == OP_STORE);
        last_next        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign take_item = in_valid && in_ready;
  assign mem_waddr = line_count[ADDR_W-1:0];
  assign mem_wdata = line_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_clr) begin
        line_count <= '0;
      end else if (cnt_inc) begin
        line_count <= line_count + LEN_W'(1);
      end else if (cnt_dec) begin
        line_count <= line_count - LEN_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      item_cmd  <= command;
      item_byte <= data_byte;
    end
    if (dec_load) begin
      term_byte   <= dec_term_byte;
      line_ch     <= dec_ch;
      op          <= dec_op;
      rel_pending <= dec_rel;
    end
    if (idx_clr) begin
      rel_idx <= '0;
    end else if (idx_inc) begin
      rel_idx <= rel_idx + LEN_W'(1);
    end
    if (out_load) begin
      destination <= destination_next;
      out_byte    <= out_byte_next;
      line_length <= line_length_next;
      line_full   <= line_full_next;
      last        <= last_next;
    end
  end

`ifndef SYNTH
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> line_count < LINE_TOP)
    else $error("line count at or above capacity while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result register loaded over an untaken result");

  a_rel_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_REL_BYTE |-> rel_idx < line_count)
    else $error("release index beyond stored bytes");

  a_store_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> line_count < LINE_TOP)
    else $error("line store written past its depth");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REL_END && slot_free) |=> line_count == '0)
    else $error("line count not cleared after end of line");
`endif

endmodule

/* tb/tld_tb_pkg.sv */
`timescale 1ns / 1ps

package tld_tb_pkg;

  // Command bit of an input transfer.
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_HOST = 1'b1;

  // Echo modes the RTL package leaves unnamed.
  localparam logic [1:0] ECHO_OFF   = 2'd0;
  localparam logic [1:0] ECHO_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]                     dest;
    logic [tld_pkg::BYTE_W-1:0]     data;
    logic [tld_pkg::LEN_W-1:0]      len;
    logic                           full;
    logic                           last;
  } tld_result_t;

endpackage

/* tb/line_discipline_checker.sv */
`timescale 1ns / 1ps

module line_discipline_checker
  import tld_pkg::*;
  import tld_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 command,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           destination,
  input  logic [BYTE_W-1:0]    out_byte,
  input  logic [LEN_W-1:0]     line_length,
  input  logic                 line_full,
  input  logic                 last,
  output int                   fail_count,
  output int                   pending
);

  localparam int LINE_CAP   = LINE_MAX_DEF;
  localparam int IDX_W      = $clog2(LINE_CAP);
  localparam int REPORT_MAX = 10;

  cfg_t              regs;
  logic [BYTE_W-1:0] line_bytes [LINE_CAP];
  logic [LEN_W-1:0]  line_fill;
  tld_result_t       line_traffic [$];
  int                fails = 0;
  int                n_pending = 0;
  int                seen = 0;

  assign fail_count = fails;
  assign pending    = n_pending;

  task automatic push_result(input logic [1:0] dest, input logic [BYTE_W-1:0] data,
                             input logic [LEN_W-1:0] len, input logic full);
    tld_result_t r;
    r.dest = dest;
    r.data = data;
    r.len  = len;
    r.full = full;
    r.last = 1'b0;
    line_traffic.push_back(r);
  endtask

  // Bytes for the terminal: a newline may gain a leading CR and is sent as CR or NL.
  task automatic to_terminal(input logic [BYTE_W-1:0] ch);
    logic [BYTE_W-1:0] b;
    b = ch;
    if (ch == NEWLINE_CHAR) begin
      if (regs.add_cr_on_output)
        push_result(DEST_TERM, regs.cr_char, '0, 1'b0);
      b = regs.cr_is_newline ? regs.cr_char : regs.nl_char;
    end
    push_result(DEST_TERM, b, '0, 1'b0);
  endtask

  task automatic flush_line(input logic full);
    int i;
    for (i = 0; i < line_fill; i++)
      push_result(DEST_LINE, line_bytes[i[IDX_W-1:0]], '0, 1'b0);
    push_result(DEST_EOL, '0, line_fill, full);
    line_fill = '0;
  endtask

  task automatic discipline_byte(input logic cmd, input logic [BYTE_W-1:0] b);
    int                n_prior;
    logic [BYTE_W-1:0] ch;
    tld_result_t       tail;
    n_prior = line_traffic.size();
    ch = b;
    if (cmd == CMD_HOST) begin
      to_terminal(b);
    end else if (!(b == regs.cr_char && regs.ignore_cr)) begin
      // CR matching wins over NL matching.
      if (b == regs.cr_char) begin
        if (regs.cr_is_newline)
          ch = NEWLINE_CHAR;
      end else if (b == regs.nl_char) begin
        ch = NEWLINE_CHAR;
      end
      if (regs.echo_mode == ECHO_RAW)
        to_terminal(ch);
      else if (regs.echo_mode == ECHO_MASK)
        to_terminal((ch >= PRINT_LO && ch <= PRINT_HI) ? regs.mask_char : ch);
      // Backspace wins over newline.
      if (ch == regs.backspace_char) begin
        if (line_fill != 0)
          line_fill--;
      end else if (ch == NEWLINE_CHAR) begin
        flush_line(1'b0);
      end else begin
        line_bytes[line_fill[IDX_W-1:0]] = ch;
        line_fill++;
        if (line_fill >= LINE_CAP)
          flush_line(1'b1);
      end
    end
    if (line_traffic.size() > n_prior) begin
      tail = line_traffic.pop_back();
      tail.last = 1'b1;
      line_traffic.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : watch
    tld_result_t got;
    tld_result_t want;
    if (rst) begin
      regs = {8'd8, 8'd13, 8'd10, 1'b0, 1'b1, 1'b1, ECHO_OFF, 8'd42};
      line_fill = '0;
      line_traffic.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BACKSPACE: regs.backspace_char   = cfg_data;
          REG_CR:        regs.cr_char          = cfg_data;
          REG_NL:        regs.nl_char          = cfg_data;
          REG_IGNORE_CR: regs.ignore_cr        = cfg_data[0];
          REG_CR_IS_NL:  regs.cr_is_newline    = cfg_data[0];
          REG_ADD_CR:    regs.add_cr_on_output = cfg_data[0];
          REG_ECHO_MODE: regs.echo_mode        = cfg_data[1:0];
          REG_MASK:      regs.mask_char        = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {destination, out_byte, line_length, line_full, last};
        seen++;
        if (line_traffic.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("result %0d unexpected: dest %0d byte %02h len %0d full %0d last %0d",
                     seen, got.dest, got.data, got.len, got.full, got.last);
        end else begin
          want = line_traffic.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("result %0d mismatch: expected dest %0d byte %02h len %0d full %0d last %0d",
                       seen, want.dest, want.data, want.len, want.full, want.last);
              $display("  got dest %0d byte %02h len %0d full %0d last %0d",
                       got.dest, got.data, got.len, got.full, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready)
        discipline_byte(command, data_byte);
    end
    n_pending = line_traffic.size();
  end

endmodule

/* tb/tb_terminal_line_discipline.sv */
`timescale 1ns / 1ps

module tb_terminal_line_discipline
  import tld_pkg::*;
  import tld_tb_pkg::*;
;

  localparam int RESET_CYCLES = 11;
  localparam int MAX_GAP      = 11;
  // Long enough to cover an item that is still being worked on without
  // producing anything (a dropped CR).
  localparam int DRAIN_CYCLES = 64;
  // Slowest correct run is under 200 items, each of whose up to LINE_MAX + 3
  // results meets the longest stall; this limit is several times that.
  localparam int CYCLE_LIMIT  = 750000;
  localparam int PHASE_ITEMS  = 26;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              command;
  logic [BYTE_W-1:0] data_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        destination;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  line_length;
  logic              line_full;
  logic              last;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  cfg_t cur;
  logic calm_in;
  logic calm_out;
  cfg_t rnd;
  int   p;

  always #5 clk = ~clk;

  terminal_line_discipline uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .destination(destination),
    .out_byte(out_byte), .line_length(line_length), .line_full(line_full), .last(last)
  );

  // The checker sees every port of the block; it follows register writes on
  // its own and works out the results of each accepted input transfer.
  line_discipline_checker line_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .destination(destination),
    .out_byte(out_byte), .line_length(line_length), .line_full(line_full), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: a hung handshake or a result that never arrives ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_terminal_line_discipline NOT OK");
      $finish;
    end
  end

  // Result side. Before every result transfer the receiver draws a random
  // stall of up to MAX_GAP; now and then it flips into a calm stretch with no
  // stalls at all, so that back-to-back line releases are exercised too.
  initial begin
    out_ready = 1'b0;
    calm_out  = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin : drain_results
      int stall;
      if ($urandom_range(0, 29) == 0)
        calm_out = ~calm_out;
      stall = calm_out ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offers one input transfer. It is entered and left just after a falling
  // edge. Valid is only lowered when a gap is drawn, so an item that follows
  // with no gap keeps valid high and merely changes the payload.
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 19) == 0)
      calm_in = ~calm_in;
    gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every predicted result has been taken and then a little
  // longer, so that an item which produces nothing has also finished.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The write enable is left high between consecutive writes; the caller
  // lowers it after the last one.
  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Writes all eight registers while the block is idle. The unused upper
  // bits of the narrow registers carry random junk, which must be masked off.
  task automatic apply_settings(input cfg_t s);
    logic [BYTE_W-1:0] junk;
    junk = BYTE_W'($urandom);
    settle();
    put_reg(REG_BACKSPACE, s.backspace_char);
    put_reg(REG_CR,        s.cr_char);
    put_reg(REG_NL,        s.nl_char);
    put_reg(REG_IGNORE_CR, {junk[7:1], s.ignore_cr});
    put_reg(REG_CR_IS_NL,  {junk[6:0], s.cr_is_newline});
    put_reg(REG_ADD_CR,    {junk[7:2], junk[0], s.add_cr_on_output});
    put_reg(REG_ECHO_MODE, {junk[5:0], s.echo_mode});
    put_reg(REG_MASK,      s.mask_char);
    cfg_write <= 1'b0;
    cur = s;
  endtask

  // Random traffic for one setting. Most of it is typed lines: ordinary
  // bytes with the odd backspace, closed by CR, NL or a plain newline byte.
  // Some lines are long enough to fill the buffer. The rest is noise (any
  // byte with either command) and host text with embedded newlines. A phase
  // may stop in the middle of a line, which then carries over.
  task automatic random_phase(input int budget);
    int                sent;
    int                len;
    int                i;
    int                k;
    logic [BYTE_W-1:0] b;
    sent = 0;
    calm_in = ($urandom_range(0, 3) == 0);
    while (sent < budget) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        if ($urandom_range(0, 3) == 0)
          len = $urandom_range(LINE_MAX_DEF - 4, LINE_MAX_DEF + 4);
        else
          len = $urandom_range(0, 10);
        for (i = 0; i < len && sent < budget; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            b = cur.backspace_char;
          end else begin
            do
              b = BYTE_W'($urandom);
            while (b == cur.cr_char || b == cur.nl_char || b == cur.backspace_char ||
                   b == NEWLINE_CHAR);
          end
          send_item(CMD_RX, b);
          sent++;
        end
        case ($urandom_range(0, 2))
          0:       b = cur.cr_char;
          1:       b = cur.nl_char;
          default: b = NEWLINE_CHAR;
        endcase
        send_item(CMD_RX, b);
        sent++;
      end else if (k < 9) begin
        b = BYTE_W'($urandom);
        send_item(1'($urandom_range(0, 1)), b);
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
          b = BYTE_W'($urandom);
          if ($urandom_range(0, 2) == 0)
            b = NEWLINE_CHAR;
          send_item(CMD_HOST, b);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = CMD_RX;
    data_byte = '0;
    calm_in   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    cur = {8'd8, 8'd13, 8'd10, 1'b0, 1'b1, 1'b1, ECHO_OFF, 8'd42};

    // Directed part, first with the register values left by reset.
    // A host newline becomes CR then CR; host bytes at both extremes.
    send_item(CMD_HOST, NEWLINE_CHAR);
    send_item(CMD_HOST, 8'h00);
    send_item(CMD_HOST, 8'hFF);
    // Backspace on an empty line is ignored and gives no transfer.
    send_item(CMD_RX, 8'h08);
    send_item(CMD_RX, 8'h41);
    send_item(CMD_RX, 8'hFF);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_RX, 8'h08);
    // CR maps to newline and releases the line; NL then releases an empty one.
    send_item(CMD_RX, 8'h0D);
    send_item(CMD_RX, 8'h0A);

    // CR and NL share a code, and backspace is the newline byte itself.
    apply_settings({8'h0A, 8'h55, 8'h55, 1'b0, 1'b0, 1'b0, ECHO_RAW, 8'h00});
    send_item(CMD_RX, 8'h78);
    // Matches CR first, and with no CR mapping stays a plain byte.
    send_item(CMD_RX, 8'h55);
    // Echoed as a newline, then acts as a backspace rather than ending the line.
    send_item(CMD_RX, NEWLINE_CHAR);
    send_item(CMD_HOST, NEWLINE_CHAR);

    // Dropped CR gives nothing at all; the spare echo mode is silent.
    apply_settings({8'h7F, 8'h0D, 8'h0A, 1'b1, 1'b1, 1'b1, ECHO_SPARE, 8'h2A});
    send_item(CMD_RX, 8'h0D);
    send_item(CMD_RX, 8'h41);
    send_item(CMD_RX, 8'h0A);

    // Masked echo at both edges of the printable range and just outside it.
    apply_settings({8'h08, 8'h0D, 8'h0A, 1'b0, 1'b1, 1'b0, ECHO_MASK, 8'h23});
    send_item(CMD_RX, PRINT_LO);
    send_item(CMD_RX, PRINT_HI);
    send_item(CMD_RX, 8'h1F);
    send_item(CMD_RX, 8'h7F);
    send_item(CMD_RX, 8'h0D);
    send_item(CMD_HOST, 8'h0D);

    // Random part over a range of settings, extremes first.
    apply_settings({8'h08, 8'h0D, 8'h0A, 1'b0, 1'b1, 1'b1, ECHO_RAW, 8'h2A});
    random_phase(PHASE_ITEMS);
    apply_settings({8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, ECHO_OFF, 8'h00});
    random_phase(PHASE_ITEMS);
    apply_settings({8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, ECHO_SPARE, 8'hFF});
    random_phase(PHASE_ITEMS);
    for (p = 0; p < 2; p++) begin
      rnd.backspace_char   = BYTE_W'($urandom);
      rnd.cr_char          = BYTE_W'($urandom);
      rnd.nl_char          = BYTE_W'($urandom);
      rnd.ignore_cr        = 1'($urandom_range(0, 1));
      rnd.cr_is_newline    = 1'($urandom_range(0, 1));
      rnd.add_cr_on_output = 1'($urandom_range(0, 1));
      rnd.echo_mode        = (p == 0) ? ECHO_MASK : 2'($urandom_range(0, 3));
      rnd.mask_char        = BYTE_W'($urandom);
      apply_settings(rnd);
      random_phase(PHASE_ITEMS);
    end
    apply_settings({8'h08, 8'h0D, 8'h0A, 1'b0, 1'b0, 1'b1, ECHO_MASK, 8'h2A});
    random_phase(PHASE_ITEMS);

    // Let every outstanding result arrive before the verdict.
    settle();
    if (fail_count == 0 && pending == 0)
      $display("tb_terminal_line_discipline OK");
    else
      $display("tb_terminal_line_discipline NOT OK");
    $finish;
  end

endmodule
